### sv/cwcm_pkg.sv
// ----------------------------------------------------------------------------
// cwcm_pkg
// Widths, constants and register indexes shared by the center window color
// mean unit and its stream interfaces.
// ----------------------------------------------------------------------------
package cwcm_pkg;

  localparam int ROW_W       = 12;  // pixel row and column
  localparam int CH_W        = 8;   // one color component
  localparam int MEAN_W      = 8;   // one mean
  localparam int CFG_W       = 13;  // configuration register data
  localparam int CFG_INDEX_W = 1;   // configuration register index
  localparam int SUM_W       = 26;  // running channel sum
  localparam int NUM_CH      = 3;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

  // floor(h / 10) == (h * RECIP_TENTH) >> RECIP_SHIFT for every h below 2^17.
  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_TENTH = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = 1'd1;

endpackage

### sv/cwcm_pixel_if.sv
// ----------------------------------------------------------------------------
// cwcm_pixel_if
// Valid/ready channel that carries one pixel with its position and the
// end-of-frame mark.
// ----------------------------------------------------------------------------
interface cwcm_pixel_if import cwcm_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pixel_row;
  logic [ROW_W-1:0] pixel_col;
  logic [CH_W-1:0]  channel0;
  logic [CH_W-1:0]  channel1;
  logic [CH_W-1:0]  channel2;
  logic             frame_end;

  modport source (
    output valid, pixel_row, pixel_col, channel0, channel1, channel2, frame_end,
    input  ready
  );

  modport sink (
    input  valid, pixel_row, pixel_col, channel0, channel1, channel2, frame_end,
    output ready
  );

endinterface

### sv/cwcm_mean_if.sv
// ----------------------------------------------------------------------------
// cwcm_mean_if
// Valid/ready channel that carries the three window means of one frame.
// ----------------------------------------------------------------------------
interface cwcm_mean_if import cwcm_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean0;
  logic [MEAN_W-1:0] mean1;
  logic [MEAN_W-1:0] mean2;
  logic              window_empty;

  modport source (
    output valid, mean0, mean1, mean2, window_empty,
    input  ready
  );

  modport sink (
    input  valid, mean0, mean1, mean2, window_empty,
    output ready
  );

endinterface

### sv/center_window_color_mean_unit.sv
// ----------------------------------------------------------------------------
// center_window_color_mean_unit
// Sums the color components of the pixels inside a centered square window
// and, on the last pixel of a frame, emits the three truncated means.
// ----------------------------------------------------------------------------
//
//   channel   direction  transaction carries
//   pixels    in         row, column, three components, end of frame
//   means     out        three means, empty-window flag
//   cfg       in         register index and data (write only)
//
// After a pixel is accepted, the sequencer steps through window size,
// window bounds and the accumulate step before it is ready again.
// A pixel that ends a frame with a non-empty window then runs each channel
// in turn through the shared restoring divider, one quotient bit per cycle,
// before the output register is loaded (later while an earlier result is untaken).
// The output register lets a new frame start while a result waits.
// Reset is synchronous and sets the registers to 480 rows by 640 columns.
// ----------------------------------------------------------------------------
module center_window_color_mean_unit import cwcm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  cwcm_pixel_if.sink             pixels,
  cwcm_mean_if.source            means
);

  localparam int DW  = $clog2(MAX_DIM + 1);  // clamped dimension
  localparam int EW  = DW + 2;               // signed window bounds
  localparam int PW  = DW + RECIP_W;         // reciprocal product
  localparam int AW  = 2 * DW;               // window area
  localparam int CW  = $clog2(SUM_W);        // divider step counter

  localparam logic [CW-1:0] LAST_STEP = CW'(SUM_W - 1);
  localparam logic [1:0]    LAST_CH   = 2'(NUM_CH - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SIDE = 7'b0000010,
    S_WIN  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] frame_rows;
  logic [CFG_W-1:0] frame_cols;

  // Latched pixel.
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [CH_W-1:0]  comp0;
  logic [CH_W-1:0]  comp1;
  logic [CH_W-1:0]  comp2;
  logic             last;

  logic [DW-1:0]        side;
  logic [AW-1:0]        area;
  logic signed [EW-1:0] top;
  logic signed [EW-1:0] top_end;
  logic signed [EW-1:0] left;
  logic signed [EW-1:0] left_end;

  logic [SUM_W-1:0] sum_first;
  logic [SUM_W-1:0] sum_second;
  logic [SUM_W-1:0] sum_third;

  // Divider.
  logic [SUM_W-1:0]  dvd;
  logic [AW-1:0]     rem;
  logic [SUM_W-1:0]  quo;
  logic [CW-1:0]     cnt;
  logic [1:0]        ch;
  logic [MEAN_W-1:0] res_mean [NUM_CH];
  logic              res_empty;

  // Output register.
  logic              out_valid;
  logic [MEAN_W-1:0] out_mean0;
  logic [MEAN_W-1:0] out_mean1;
  logic [MEAN_W-1:0] out_mean2;
  logic              out_empty;

  logic [DW-1:0]        h_c;
  logic [DW-1:0]        w_c;
  logic [PW-1:0]        side_prod;
  logic signed [EW-1:0] side_s;
  logic signed [EW-1:0] top_v;
  logic signed [EW-1:0] left_v;
  logic signed [EW-1:0] row_s;
  logic signed [EW-1:0] col_s;
  logic                 in_win;
  logic [SUM_W:0]       add0;
  logic [SUM_W:0]       add1;
  logic [SUM_W:0]       add2;
  logic [SUM_W-1:0]     sel_sum;
  logic [AW:0]          trial;
  logic                 fits;
  logic [AW-1:0]        rem_next;
  logic [SUM_W-1:0]     quo_next;
  logic [MEAN_W-1:0]    mean_sat;
  logic                 out_free;

  // Dimensions above the supported maximum are taken as the maximum.
  always_comb begin
    h_c = (32'(frame_rows) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_rows);
    w_c = (32'(frame_cols) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_cols);
  end

  assign side_prod = PW'(h_c) * PW'(RECIP_TENTH);
  assign side_s    = $signed(EW'(side));
  // Height never falls below the side, but the width may, so left can go
  // negative; the arithmetic shift floors it.
  assign top_v     = ($signed(EW'(h_c)) - side_s) >>> 1;
  assign left_v    = ($signed(EW'(w_c)) - side_s) >>> 1;

  assign row_s  = $signed(EW'(row));
  assign col_s  = $signed(EW'(col));
  assign in_win = (row_s >= top) && (row_s < top_end) &&
                  (col_s >= left) && (col_s < left_end);

  assign add0 = {1'b0, sum_first}  + (SUM_W + 1)'(comp0);
  assign add1 = {1'b0, sum_second} + (SUM_W + 1)'(comp1);
  assign add2 = {1'b0, sum_third}  + (SUM_W + 1)'(comp2);

  always_comb begin
    unique case (ch)
      2'd0:    sel_sum = sum_first;
      2'd1:    sel_sum = sum_second;
      default: sel_sum = sum_third;
    endcase
  end

  // One restoring division step; the partial remainder stays below the area.
  assign trial    = {rem, dvd[SUM_W-1]};
  assign fits     = trial >= {1'b0, area};
  assign rem_next = fits ? AW'(trial - {1'b0, area}) : AW'(trial);
  assign quo_next = {quo[SUM_W-2:0], fits};
  assign mean_sat = (|quo_next[SUM_W-1:MEAN_W]) ? MEAN_MAX : quo_next[MEAN_W-1:0];

  assign out_free = !out_valid || means.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= HEIGHT_RESET;
      frame_cols <= WIDTH_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        REG_FRAME_COLS: frame_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sum_first  <= '0;
      sum_second <= '0;
      sum_third  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && means.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixels.valid) begin
            state <= S_SIDE;
          end
        end
        S_SIDE: begin
          state <= S_WIN;
        end
        S_WIN: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (in_win) begin
            sum_first  <= add0[SUM_W] ? SUM_MAX : add0[SUM_W-1:0];
            sum_second <= add1[SUM_W] ? SUM_MAX : add1[SUM_W-1:0];
            sum_third  <= add2[SUM_W] ? SUM_MAX : add2[SUM_W-1:0];
          end
          priority if (!last) begin
            state <= S_IDLE;
          end else if (side == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == LAST_STEP) begin
            state <= (ch == LAST_CH) ? S_OUT : S_LOAD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            sum_first  <= '0;
            sum_second <= '0;
            sum_third  <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; the sequencer above decides when they matter.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        row   <= pixels.pixel_row;
        col   <= pixels.pixel_col;
        comp0 <= pixels.channel0;
        comp1 <= pixels.channel1;
        comp2 <= pixels.channel2;
        last  <= pixels.frame_end;
        ch    <= '0;
      end
      S_SIDE: begin
        side <= DW'(side_prod >> RECIP_SHIFT);
      end
      S_WIN: begin
        top      <= top_v;
        top_end  <= top_v + side_s;
        left     <= left_v;
        left_end <= left_v + side_s;
        area     <= AW'(side) * AW'(side);
      end
      S_ACC: begin
        res_empty <= (side == '0);
        for (int i = 0; i < NUM_CH; i++) begin
          res_mean[i] <= '0;
        end
      end
      S_LOAD: begin
        dvd <= sel_sum;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        dvd <= dvd << 1;
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          res_mean[ch] <= mean_sat;
          ch           <= ch + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_mean0 <= res_mean[0];
          out_mean1 <= res_mean[1];
          out_mean2 <= res_mean[2];
          out_empty <= res_empty;
        end
      end
      default: ;
    endcase
  end

  assign pixels.ready       = (state == S_IDLE);
  assign means.valid        = out_valid;
  assign means.mean0        = out_mean0;
  assign means.mean1        = out_mean1;
  assign means.mean2        = out_mean2;
  assign means.window_empty = out_empty;

endmodule
